[rtl/elrf_pkg.sv]
// Shared types and constants for the event log ring framer.
// Used by every module of the block except elrf_ram; depends on nothing.
package elrf_pkg;

  localparam int unsigned ENTRY_COUNT = 256;
  localparam int unsigned PTR_W       = $clog2(ENTRY_COUNT);
  localparam int unsigned ENTRY_W     = 64;

  localparam int unsigned FRAME_LEN   = 10;
  localparam int unsigned IDX_W       = $clog2(FRAME_LEN);
  localparam logic [7:0]  FRAME_HEAD  = 8'hAA;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] HB_PERIOD_RST = 32'd1000;
  localparam logic [7:0]  HB_TYPE_RST   = 8'd0;

  typedef enum logic [1:0] {
    MODE_LOG   = 2'd0,
    MODE_DRAIN = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  typedef enum logic {
    CFG_HB_PERIOD = 1'b0,
    CFG_HB_TYPE   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         event_type;
    logic signed [15:0] value_first;
    logic signed [15:0] value_second;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_of_frame;
    logic       ring_empty;
    logic       overflow_seen;
  } out_item_t;

  // One drain request as seen by the serializer
  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic               empty;
    logic               ovf;
  } drain_cmd_t;

endpackage

[rtl/elrf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module elrf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/elrf_front.sv]
// Front end: accepts items, keeps ring pointers, overflow and heartbeat state.
// Owns the entry RAM and issues drain requests. Depends on elrf_pkg, elrf_ram.
module elrf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  elrf_pkg::in_item_t            in_data_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic [elrf_pkg::QLVL_W-1:0]   q_level_i,
  output logic                          push_o,
  output elrf_pkg::drain_cmd_t          push_cmd_o
);
  import elrf_pkg::*;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_W'(ENTRY_COUNT - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [PTR_W-1:0]   wp_q, rp_q, wp_next, rp_next;
  logic               ovf_q;
  logic [31:0]        last_hb_q, period_q;
  logic [7:0]         hb_type_q;
  logic               pend_q, pend_empty_q, pend_ovf_q;
  logic               accept, is_log, is_hb, is_drain, wr, empty, hb_due;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic [QLVL_W:0]    busy;

  assign busy       = {1'b0, q_level_i} + (QLVL_W + 1)'(pend_q);
  assign in_ready_o = busy < (QLVL_W + 1)'(QUEUE_DEPTH);
  assign accept     = in_valid_i && in_ready_o;
  assign empty      = (rp_q == wp_q);
  assign hb_due     = (in_data_i.time_ms - last_hb_q) >= period_q;
  assign wp_next    = ring_next(wp_q);
  assign rp_next    = ring_next(rp_q);

  always_comb begin
    is_log   = 1'b0;
    is_hb    = 1'b0;
    is_drain = 1'b0;
    unique case (mode_e'(in_data_i.mode))
      MODE_LOG:   is_log   = accept;
      MODE_DRAIN: is_drain = accept;
      MODE_TICK:  is_hb    = accept && hb_due;
      default: ;
    endcase
  end

  assign wr    = is_log || is_hb;
  assign wdata = is_log ? {in_data_i.value_second[7:0], in_data_i.value_first,
                           in_data_i.time_ms, in_data_i.event_type}
                        : {24'd0, in_data_i.time_ms, hb_type_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= '0;
      rp_q         <= '0;
      ovf_q        <= 1'b0;
      last_hb_q    <= '0;
      period_q     <= HB_PERIOD_RST;
      hb_type_q    <= HB_TYPE_RST;
      pend_q       <= 1'b0;
      pend_empty_q <= 1'b0;
      pend_ovf_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_HB_PERIOD: period_q  <= cfg_wdata_i;
          CFG_HB_TYPE:   hb_type_q <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (is_hb) begin
        last_hb_q <= in_data_i.time_ms;
      end
      if (wr) begin
        wp_q <= wp_next;
        // Drop the oldest entry when the ring is full
        if (wp_next == rp_q) begin
          rp_q  <= rp_next;
          ovf_q <= 1'b1;
        end
      end else if (is_drain && !empty) begin
        rp_q <= rp_next;
      end
      pend_q       <= is_drain;
      pend_empty_q <= empty;
      pend_ovf_q   <= ovf_q;
    end
  end

  elrf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRY_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr),
    .waddr_i (wp_q),
    .wdata_i (wdata),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  assign push_o           = pend_q;
  assign push_cmd_o.entry = rdata;
  assign push_cmd_o.empty = pend_empty_q;
  assign push_cmd_o.ovf   = pend_ovf_q;

  a_ring_not_empty_after_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni) wr |=> (wp_q != rp_q)
  ) else $error("ring reads empty after a write");

  a_ovf_sticky: assert property (
    @(posedge clk_i) disable iff (!rst_ni) ovf_q |=> ovf_q
  ) else $error("overflow flag cleared");

  a_push_follows_drain: assert property (
    @(posedge clk_i) disable iff (!rst_ni) is_drain |=> push_o
  ) else $error("drain request lost");

endmodule

[rtl/elrf_queue.sv]
// Short FIFO of drain requests between the front end and the serializer.
// Depends on elrf_pkg.
module elrf_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  elrf_pkg::drain_cmd_t        push_cmd_i,
  input  logic                        pop_i,
  output elrf_pkg::drain_cmd_t        head_o,
  output logic                        nonempty_o,
  output logic [elrf_pkg::QLVL_W-1:0] level_o
);
  import elrf_pkg::*;

  drain_cmd_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QLVL_W-1:0]  level_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      level_q <= level_q + QLVL_W'(push_i) - QLVL_W'(pop_i);
    end
  end

  assign head_o     = slot_q[rd_q];
  assign nonempty_o = (level_q != '0);
  assign level_o    = level_q;

  a_no_overrun: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (level_q < QLVL_W'(QUEUE_DEPTH)) || pop_i
  ) else $error("queue overrun");

  a_no_underrun: assert property (
    @(posedge clk_i) disable iff (!rst_ni) pop_i |-> nonempty_o
  ) else $error("queue underrun");

  a_level_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni) level_q <= QLVL_W'(QUEUE_DEPTH)
  ) else $error("queue level out of range");

endmodule

[rtl/elrf_back.sv]
// Back end: serializes one drain request into a ten-byte frame or an empty marker.
// Depends on elrf_pkg.
module elrf_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  elrf_pkg::drain_cmd_t   head_i,
  input  logic                   nonempty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output elrf_pkg::out_item_t    out_data_o
);
  import elrf_pkg::*;

  drain_cmd_t       cmd_q;
  logic             active_q;
  logic [IDX_W-1:0] idx_q;
  logic             last, out_fire;
  logic [2:0]       bsel;
  logic [7:0]       csum, body;

  assign last     = cmd_q.empty || (idx_q == IDX_W'(FRAME_LEN - 1));
  assign out_fire = active_q && out_ready_i;
  assign pop_o    = nonempty_i && (!active_q || (out_fire && last));
  assign bsel     = 3'(idx_q - 1'b1);
  assign body     = cmd_q.entry[{bsel, 3'b000} +: 8];

  always_comb begin
    csum = '0;
    for (int i = 0; i < 8; i++) begin
      csum = csum ^ cmd_q.entry[i*8 +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
    end else if (pop_o) begin
      active_q <= 1'b1;
      idx_q    <= '0;
    end else if (out_fire) begin
      if (last) begin
        active_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_comb begin
    if (cmd_q.empty) begin
      out_data_o.frame_byte = '0;
    end else if (idx_q == '0) begin
      out_data_o.frame_byte = FRAME_HEAD;
    end else if (idx_q == IDX_W'(FRAME_LEN - 1)) begin
      out_data_o.frame_byte = csum;
    end else begin
      out_data_o.frame_byte = body;
    end
    out_data_o.last_of_frame = last;
    out_data_o.ring_empty    = cmd_q.empty;
    out_data_o.overflow_seen = cmd_q.ovf;
  end

  assign out_valid_o = active_q;

  a_idx_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni) active_q |-> idx_q < IDX_W'(FRAME_LEN)
  ) else $error("frame index out of range");

  a_empty_single: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (active_q && cmd_q.empty) |-> (idx_q == '0) && last
  ) else $error("empty marker spans more than one transfer");

endmodule

[rtl/event_log_ring_framer.sv]
// Event trace buffer: log (mode 0) and heartbeat tick (mode 2) items are
// absorbed and produce nothing; a drain (mode 1) yields a ten-byte frame, one
// byte per output transfer, or a single empty marker. Drain requests sit in a
// four-deep queue, which a request enters the cycle after its drain is accepted.
// Depends on elrf_pkg, elrf_front, elrf_queue, elrf_back.
module event_log_ring_framer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  elrf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output elrf_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i
);
  import elrf_pkg::*;

  logic              push, pop, nonempty;
  drain_cmd_t        push_cmd, head;
  logic [QLVL_W-1:0] level;

  elrf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_level_i   (level),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  elrf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .nonempty_o (nonempty),
    .level_o    (level)
  );

  elrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .nonempty_i  (nonempty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
